### src/pfa_pkg.sv
package pfa_pkg;

    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 17;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Kernel image starts at 4 MiB; with 4 KiB frames that is frame 1024.
    localparam logic [31:0]      KERNEL_BASE_ADDR = 32'h0040_0000;
    localparam int               PAGE_SHIFT       = 12;
    localparam logic [CFG_W-1:0] KSTART_RESET     = CFG_W'(KERNEL_BASE_ADDR >> PAGE_SHIFT);
    localparam logic [CFG_W-1:0] PAGE_SPACE       = 17'h1_0000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic [1:0] REG_KERNEL_START = 2'd0;
    localparam logic [1:0] REG_KERNEL_TOP   = 2'd1;
    localparam logic [1:0] REG_MEMORY_TOP   = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC_KERNEL = 2'd0,
        CMD_ALLOC_USER   = 2'd1,
        CMD_RELEASE      = 2'd2,
        CMD_ADD_REF      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_NO_FREE      = 3'd1,
        STS_OUT_OF_RANGE = 3'd2,
        STS_ALREADY_FREE = 3'd3,
        STS_SATURATED    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [PAGE_W-1:0] page;
    } pfa_in_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page_out;
        status_t            status;
        logic [COUNT_W-1:0] count_after;
    } pfa_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] kernel_start;
        logic [CFG_W-1:0] kernel_top;
        logic [CFG_W-1:0] memory_top;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [PAGE_W-1:0]  waddr;
        logic [COUNT_W-1:0] wdata;
        logic               re;
        logic [PAGE_W-1:0]  raddr;
    } ram_req_t;

endpackage

### src/pfa_count_ram.sv
module pfa_count_ram
    import pfa_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic               aclk,
    input  ram_req_t           req,
    output logic [COUNT_W-1:0] rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/pfa_cfg_regs.sv
module pfa_cfg_regs
    import pfa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CFG_W-1:0] kstart_reg, kstart_next;
    logic [CFG_W-1:0] ktop_reg, ktop_next;
    logic [CFG_W-1:0] mtop_reg, mtop_next;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        kstart_next = kstart_reg;
        ktop_next   = ktop_reg;
        mtop_next   = mtop_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_KERNEL_START: kstart_next = pwdata[CFG_W-1:0];
                REG_KERNEL_TOP:   ktop_next   = pwdata[CFG_W-1:0];
                REG_MEMORY_TOP:   mtop_next   = pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kstart_reg <= KSTART_RESET;
            ktop_reg   <= PAGE_SPACE;
            mtop_reg   <= PAGE_SPACE;
        end else begin
            kstart_reg <= kstart_next;
            ktop_reg   <= ktop_next;
            mtop_reg   <= mtop_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KERNEL_START: prdata = APB_DW'(kstart_reg);
            REG_KERNEL_TOP:   prdata = APB_DW'(ktop_reg);
            REG_MEMORY_TOP:   prdata = APB_DW'(mtop_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.kernel_start = kstart_reg;
    assign cfg.kernel_top   = ktop_reg;
    assign cfg.memory_top   = mtop_reg;

endmodule

### src/pfa_engine.sv
module pfa_engine
    import pfa_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536,
    parameter int AW          = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfa_in_t            in_data,
    input  logic               out_free,
    output logic               res_valid,
    output pfa_out_t           res_data,
    output ram_req_t           ram_req,
    input  logic [COUNT_W-1:0] ram_rdata
);

    localparam logic [CFG_W-1:0] TABLE_LIMIT = CFG_W'(TABLE_DEPTH);
    localparam logic [AW-1:0]    CLR_LAST    = AW'(TABLE_DEPTH - 1);

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [PAGE_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [CFG_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [CFG_W-1:0]   scan_hi_reg, scan_hi_next;
    logic               user_phase_reg, user_phase_next;
    cmd_t               cmd_reg, cmd_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    pfa_out_t           res_reg, res_next;
    logic               wr_en_reg, wr_en_next;
    logic [PAGE_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [COUNT_W-1:0] wr_data_reg, wr_data_next;

    logic [CFG_W-1:0]   page_ext;
    logic               in_range;

    function automatic logic [CFG_W-1:0] clip(input logic [CFG_W-1:0] v);
        return (v < TABLE_LIMIT) ? v : TABLE_LIMIT;
    endfunction

    assign page_ext = {1'b0, in_data.page};
    assign in_range = (page_ext < cfg.memory_top) && (page_ext < TABLE_LIMIT);

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        rd_valid_next   = rd_valid_reg;
        rd_addr_next    = rd_addr_reg;
        scan_addr_next  = scan_addr_reg;
        scan_hi_next    = scan_hi_reg;
        user_phase_next = user_phase_reg;
        cmd_next        = cmd_reg;
        page_next       = page_reg;
        res_next        = res_reg;
        wr_en_next      = wr_en_reg;
        wr_addr_next    = wr_addr_reg;
        wr_data_next    = wr_data_reg;
        ram_req         = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = PAGE_W'(clr_addr_reg);
                ram_req.wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next      = in_data.cmd;
                    page_next     = in_data.page;
                    rd_valid_next = 1'b0;
                    case (in_data.cmd)
                        CMD_ALLOC_KERNEL: begin
                            scan_addr_next  = cfg.kernel_start;
                            scan_hi_next    = clip(cfg.kernel_top);
                            user_phase_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        CMD_ALLOC_USER: begin
                            scan_addr_next  = cfg.kernel_top;
                            scan_hi_next    = clip(cfg.memory_top);
                            user_phase_next = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            if (in_range) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = in_data.page;
                                state_next    = ST_MODIFY;
                            end else begin
                                res_next   = '{page_out: in_data.page,
                                               status: STS_OUT_OF_RANGE,
                                               count_after: '0};
                                wr_en_next = 1'b0;
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_valid_reg && (ram_rdata == '0)) begin
                    // free frame found: claim it with a count of one
                    res_next      = '{page_out: rd_addr_reg, status: STS_OK,
                                      count_after: COUNT_W'(1)};
                    wr_en_next    = 1'b1;
                    wr_addr_next  = rd_addr_reg;
                    wr_data_next  = COUNT_W'(1);
                    rd_valid_next = 1'b0;
                    state_next    = ST_EMIT;
                end else if (scan_addr_reg < scan_hi_reg) begin
                    ram_req.re     = 1'b1;
                    ram_req.raddr  = scan_addr_reg[PAGE_W-1:0];
                    rd_valid_next  = 1'b1;
                    rd_addr_next   = scan_addr_reg[PAGE_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end else begin
                    rd_valid_next = 1'b0;
                    if (!rd_valid_reg) begin
                        if (user_phase_reg) begin
                            // user region exhausted, fall back to kernel region
                            scan_addr_next  = cfg.kernel_start;
                            scan_hi_next    = clip(cfg.kernel_top);
                            user_phase_next = 1'b0;
                        end else begin
                            res_next   = '{page_out: '0, status: STS_NO_FREE,
                                           count_after: '0};
                            wr_en_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_MODIFY: begin
                wr_addr_next = page_reg;
                if (cmd_reg == CMD_RELEASE) begin
                    if (ram_rdata == '0) begin
                        res_next   = '{page_out: page_reg, status: STS_ALREADY_FREE,
                                       count_after: '0};
                        wr_en_next = 1'b0;
                    end else begin
                        res_next     = '{page_out: page_reg, status: STS_OK,
                                         count_after: ram_rdata - 1'b1};
                        wr_en_next   = 1'b1;
                        wr_data_next = ram_rdata - 1'b1;
                    end
                end else begin
                    if (ram_rdata == COUNT_MAX) begin
                        res_next   = '{page_out: page_reg, status: STS_SATURATED,
                                       count_after: COUNT_MAX};
                        wr_en_next = 1'b0;
                    end else begin
                        res_next     = '{page_out: page_reg, status: STS_OK,
                                         count_after: ram_rdata + 1'b1};
                        wr_en_next   = 1'b1;
                        wr_data_next = ram_rdata + 1'b1;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    if (wr_en_reg) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = wr_addr_reg;
                        ram_req.wdata = wr_data_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg    <= rd_addr_next;
        scan_addr_reg  <= scan_addr_next;
        scan_hi_reg    <= scan_hi_next;
        user_phase_reg <= user_phase_next;
        cmd_reg        <= cmd_next;
        page_reg       <= page_next;
        res_reg        <= res_next;
        wr_en_reg      <= wr_en_next;
        wr_addr_reg    <= wr_addr_next;
        wr_data_reg    <= wr_data_next;
    end

    assign res_data = res_reg;

endmodule

### src/page_frame_refcount_allocator_core.sv
// Release / add-reference: the count is read, then modified and the result registered; an
//   out-of-range page goes straight to the result. Allocation reads frames of its region in
//   turn until a free one is found, a user request falling back to the kernel region; a
//   stalled output adds its wait. One command in flight: the next word can be taken in the
//   cycle after the result word is registered, while it may still wait. Reset (aresetn low,
//   synchronous) clears the count memory with s_ready low; config registers at once.
module page_frame_refcount_allocator_core
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfa_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pfa_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Only frames that a 16-bit page number can name are ever held.
    localparam int TABLE_DEPTH = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
    localparam int AW          = $clog2(TABLE_DEPTH);

    cfg_t               cfg;
    ram_req_t           ram_req;
    logic [COUNT_W-1:0] ram_rdata;
    logic               res_valid;
    pfa_out_t           res_data;
    logic               out_free;

    logic               m_valid_reg, m_valid_next;
    pfa_out_t           m_data_reg, m_data_next;

    // Register file: region bounds over APB; the user writes them only while idle, not enforced here.
    pfa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Reference counts, one byte per frame, single write and single read port.
    pfa_count_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Sequencer: clearing pass, first-fit scan and read-modify-write of counts.
    // The write-back happens as the result leaves, before the next word can be
    // taken, so a following read of the same frame always sees the new count.
    pfa_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Output register: hold the result word until taken, refill in the same
    // cycle as it leaves.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Reset always starts the clearing pass, so no word is taken straight after.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken before the count memory was cleared");

    // One command at a time: the engine is busy right after taking a word.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while a command is in flight");

    // A new result must never overwrite a word that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !res_valid)
        else $error("result overwrote a waiting output word");

    // A failed allocation reports frame zero with a zero count.
    a_no_free_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STS_NO_FREE)) |->
            ((m_data.page_out == '0) && (m_data.count_after == '0)))
        else $error("no-free result carries a frame or a count");

endmodule

### sim/tb.sv
module tb;
    import pfa_pkg::*;

    // Run limit, in clock cycles, for the clearing pass after reset and the stimulus.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // The count table of the default build covers the whole 16-bit page space.
    localparam int unsigned TABLE_SIZE  = 65536;
    // Idle chance per cycle on either side, in percent.
    localparam int unsigned IDLE_PCT    = 13;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pfa_in_t           s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pfa_out_t          m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    page_frame_refcount_allocator_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow of the allocator: one count per frame plus the three limits.
    logic [COUNT_W-1:0] frame_refs [0:TABLE_SIZE-1];
    logic [CFG_W-1:0]   k_start = KSTART_RESET;
    logic [CFG_W-1:0]   k_top   = PAGE_SPACE;
    logic [CFG_W-1:0]   m_top   = PAGE_SPACE;

    pfa_in_t     pending_words [$];
    pfa_out_t    expected_results [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    // Set during a stretch in which neither side may idle.
    bit          steady      = 1'b0;

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++)
            frame_refs[i] = '0;
    end

    // First-fit search of [lo, hi), clipped to the table. Claim the first
    // zero-count frame found and hand it back.
    function automatic bit claim_first_free(int unsigned lo, int unsigned hi,
                                            output logic [PAGE_W-1:0] frame);
        int unsigned scan_end;
        scan_end = (hi < TABLE_SIZE) ? hi : TABLE_SIZE;
        frame    = '0;
        for (int unsigned i = lo; i < scan_end; i++) begin
            if (frame_refs[i] == '0) begin
                frame_refs[i] = 8'd1;
                frame         = PAGE_W'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one command word to the shadow and return the result word it owes.
    function automatic pfa_out_t apply_command(pfa_in_t w);
        pfa_out_t          r;
        logic [PAGE_W-1:0] frame;
        bit                got;
        r.page_out    = '0;
        r.status      = STS_OK;
        r.count_after = '0;
        got           = 1'b0;
        case (w.cmd)
            CMD_ALLOC_KERNEL, CMD_ALLOC_USER: begin
                // User requests try their own region first, then fall back.
                if (w.cmd == CMD_ALLOC_USER)
                    got = claim_first_free(k_top, m_top, frame);
                if (!got)
                    got = claim_first_free(k_start, k_top, frame);
                if (got) begin
                    r.page_out    = frame;
                    r.count_after = 8'd1;
                end else begin
                    r.status = STS_NO_FREE;
                end
            end
            default: begin
                r.page_out = w.page;
                if ({1'b0, w.page} >= m_top) begin
                    r.status = STS_OUT_OF_RANGE;
                end else if (w.cmd == CMD_RELEASE) begin
                    if (frame_refs[w.page] == '0) begin
                        r.status = STS_ALREADY_FREE;
                    end else begin
                        frame_refs[w.page] = frame_refs[w.page] - 8'd1;
                        r.count_after      = frame_refs[w.page];
                    end
                end else begin
                    if (frame_refs[w.page] == COUNT_MAX)
                        r.status = STS_SATURATED;
                    else
                        frame_refs[w.page] = frame_refs[w.page] + 8'd1;
                    r.count_after = frame_refs[w.page];
                end
            end
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Command driver: present the next pending word, idling now and then.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // Hold valid and payload until the word is taken; only then move on.
            if (pending_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on every taken command word, check every taken result word.
    always @(posedge aclk) begin
        pfa_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_command(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("result word with nothing outstanding, page_out", 0,
                                  m_data.page_out);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.page_out !== want.page_out)
                        note_mismatch("page_out", want.page_out, m_data.page_out);
                    if (m_data.status !== want.status)
                        note_mismatch("status", want.status, m_data.status);
                    if (m_data.count_after !== want.count_after)
                        note_mismatch("count_after", want.count_after, m_data.count_after);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; the register lands at the
    // access edge, so update the shadow limits there too. Junk goes into the
    // bits above the register width, which the block must drop.
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= ($urandom & 32'hFFFE_0000) | APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KERNEL_START: k_start = value;
            REG_KERNEL_TOP:   k_top   = value;
            default:          m_top   = value;
        endcase
    endtask

    task automatic set_limits(logic [CFG_W-1:0] ks, logic [CFG_W-1:0] kt, logic [CFG_W-1:0] mt);
        write_reg(REG_KERNEL_START, ks);
        write_reg(REG_KERNEL_TOP, kt);
        write_reg(REG_MEMORY_TOP, mt);
    endtask

    // Wait until every word is taken and answered, then idle on so that nothing
    // is still in flight before the next write.
    task automatic drain();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic void queue_word(cmd_t c, logic [PAGE_W-1:0] p);
        pfa_in_t w;
        w.cmd  = c;
        w.page = p;
        pending_words.push_back(w);
    endfunction

    // Random traffic: mostly pages in [lo, hi), where the live frames of the
    // current setting sit, the rest anywhere in the 16-bit space.
    function automatic void queue_traffic(int unsigned n, int unsigned lo, int unsigned hi);
        int unsigned pick;
        logic [PAGE_W-1:0] p;
        cmd_t c;
        for (int unsigned k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 22)
                c = CMD_ALLOC_KERNEL;
            else if (pick < 44)
                c = CMD_ALLOC_USER;
            else if (pick < 78)
                c = CMD_RELEASE;
            else
                c = CMD_ADD_REF;
            if ($urandom_range(9) < 7)
                p = PAGE_W'(lo + $urandom_range(hi - lo - 1));
            else
                p = PAGE_W'($urandom);
            queue_word(c, p);
        end
    endfunction

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limits: kernel from frame 1024, user region empty, so user
        // requests always fall back to the kernel scan.
        queue_word(CMD_ALLOC_KERNEL, 16'hFFFF);
        queue_word(CMD_ALLOC_USER, 16'h0000);
        queue_word(CMD_RELEASE, 16'd1024);
        queue_word(CMD_RELEASE, 16'd1024);       // release of a free frame
        queue_word(CMD_ADD_REF, 16'h0000);       // add-reference on a free frame
        queue_word(CMD_RELEASE, 16'h0000);
        queue_word(CMD_ADD_REF, 16'hFFFF);
        queue_word(CMD_ALLOC_KERNEL, 16'h1234);  // first fit reuses frame 1024
        queue_word(CMD_RELEASE, 16'hFFFF);
        queue_word(CMD_RELEASE, 16'hFFFF);
        queue_word(CMD_ADD_REF, 16'd1025);
        queue_word(CMD_RELEASE, 16'd1025);
        queue_word(CMD_RELEASE, 16'hAAAA);
        queue_word(CMD_RELEASE, 16'h5555);
        // Drive one frame up into saturation, then step it back down once.
        for (int k = 0; k < 256; k++)
            queue_word(CMD_ADD_REF, 16'h8000);
        queue_word(CMD_RELEASE, 16'h8000);
        queue_traffic(150, 1000, 1100);
        drain();

        // Tiny regions: both fill quickly, so no-free and out-of-range are common.
        set_limits(17'd100, 17'd108, 17'd116);
        queue_word(CMD_RELEASE, 16'd116);
        queue_word(CMD_ADD_REF, 16'd115);
        queue_word(CMD_ADD_REF, 16'd116);
        queue_word(CMD_RELEASE, 16'hFFFF);
        queue_traffic(300, 96, 124);
        drain();

        // Kernel region at the very top of the page space, user region empty.
        set_limits(17'd65528, PAGE_SPACE, PAGE_SPACE);
        queue_traffic(150, 65520, 65536);
        drain();

        // Kernel region from frame zero, user region up to the top.
        set_limits(17'd0, 17'd16, PAGE_SPACE);
        queue_traffic(250, 0, 80);
        drain();

        // Inverted kernel range and no memory: nothing to hand out, every page out of range.
        set_limits(17'd40, 17'd20, 17'd0);
        queue_traffic(60, 0, 48);
        drain();

        // Kernel start at the limit: empty scans; only the low frames are in range.
        set_limits(PAGE_SPACE, PAGE_SPACE, 17'd30);
        queue_traffic(60, 20, 40);
        drain();

        // Small regions again, first with both sides running flat out.
        set_limits(17'd200, 17'd212, 17'd224);
        steady = 1'b1;
        queue_traffic(200, 196, 230);
        drain();
        steady = 1'b0;
        set_limits(17'd200, 17'd212, 17'd224);
        queue_traffic(100, 196, 230);
        drain();

        // Let any stray result word show up before the verdict.
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
